[sv/idsc_pkg.sv]
// Shared types and constants for the image difference scorer.
`default_nettype none
package idsc_pkg;

    localparam int TOL_W   = 14;
    localparam int LEVEL_W = 8;
    localparam int COUNT_W = 23;
    localparam int MAXD_W  = 16;
    localparam int PCT_SCALE = 10000;
    localparam int QUO_BITS  = 14;

    typedef struct packed {
        logic [31:0] actual_pixel;
        logic [31:0] base_pixel;
        logic        last_pixel;
    } t_pixel_in;

    typedef struct packed {
        logic [LEVEL_W-1:0] diff_level;
        logic               summary_valid;
        logic [TOL_W-1:0]   difference_hundredths;
        logic               failed;
        logic [COUNT_W-1:0] different_count;
        logic [MAXD_W-1:0]  max_distance;
    } t_result;

endpackage
`default_nettype wire

[sv/idsc_fifo.sv]
// Small register queue used between the pipeline parts.
`default_nettype none
module idsc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_wdata,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_empty,
    output logic [W-1:0]      o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    ap_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH))
        else $error("queue count above depth");
    ap_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not grow on push");
    ap_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("queue count did not shrink on pop");

endmodule
`default_nettype wire

[sv/idsc_front.sv]
// Front part: per-pixel distance by bit-serial divides and square root.
`default_nettype none
module idsc_front #(
    parameter int F = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire idsc_pkg::t_pixel_in i_pixel,
    output logic                     o_busy,
    output logic                     o_q_push,
    output logic [F+1:0]             o_q_data,
    input  wire logic                i_q_full
);
    localparam int R  = F + 2;
    localparam int CW = $clog2(R + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;

    logic [2:0]     r_state;
    logic [8:0]     r_rem [4];
    logic [F:0]     r_quo [4];
    logic [7:0]     r_den [4];
    logic [CW-1:0]  r_cnt;
    logic [2*R-1:0] r_acc;
    logic [2*F+1:0] r_prod;
    logic [R+2:0]   r_srem;
    logic [R-1:0]   r_root;
    logic           r_last;

    logic [7:0]     in_den [4];
    logic [7:0]     in_num [4];
    logic [2*F+1:0] sq_ext;
    logic [R+2:0]   s_rem2, s_trial;
    logic [R-2:0]   pix_dist;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic [7:0] a, b;
            a = i_pixel.actual_pixel[8*k +: 8];
            b = i_pixel.base_pixel[8*k +: 8];
            in_den[k] = ((8'd255 - b) > b) ? (8'd255 - b) : b;
            in_num[k] = (a >= b) ? (a - b) : (b - a);
        end
        sq_ext   = (2*F+2)'(r_quo[r_cnt[1:0]]);
        s_rem2   = {r_srem[R:0], r_acc[2*R-1 -: 2]};
        s_trial  = (R+3)'({r_root, 2'b01});
        pix_dist = r_root[R-1:1];
        if (pix_dist > (R-1)'(1) << F) begin
            pix_dist = (R-1)'(1) << F;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_q_push = (r_state == S_PUSH);
    assign o_q_data = {r_last, pix_dist[F:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_push) r_state <= S_DIV;
                S_DIV:  if (r_cnt == CW'(F)) r_state <= S_SQ;
                S_SQ:   if (r_cnt == CW'(4)) r_state <= S_ROOT;
                S_ROOT: if (r_cnt == CW'(R)) r_state <= S_PUSH;
                S_PUSH: if (!i_q_full) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_last <= i_pixel.last_pixel;
                r_cnt  <= CW'(1);
                for (int k = 0; k < 4; k++) begin
                    r_den[k] <= in_den[k];
                    // a channel at full scale gives exactly one
                    if (in_num[k] == in_den[k]) begin
                        r_quo[k] <= (F+1)'(1);
                        r_rem[k] <= '0;
                    end else begin
                        r_quo[k] <= '0;
                        r_rem[k] <= 9'(in_num[k]);
                    end
                end
            end
            S_DIV: begin
                for (int k = 0; k < 4; k++) begin
                    logic [8:0] t;
                    t = {r_rem[k][7:0], 1'b0};
                    if (t >= 9'(r_den[k])) begin
                        r_rem[k] <= t - 9'(r_den[k]);
                        r_quo[k] <= {r_quo[k][F-1:0], 1'b1};
                    end else begin
                        r_rem[k] <= t;
                        r_quo[k] <= {r_quo[k][F-1:0], 1'b0};
                    end
                end
                if (r_cnt == CW'(F)) begin
                    r_cnt  <= '0;
                    r_acc  <= '0;
                    r_prod <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            S_SQ: begin
                r_acc <= r_acc + (2*R)'(r_prod);
                if (r_cnt < CW'(4)) begin
                    r_prod <= sq_ext * sq_ext;
                end
                if (r_cnt == CW'(4)) begin
                    r_cnt  <= '0;
                    r_srem <= '0;
                    r_root <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            S_ROOT: begin
                if (r_cnt != CW'(R)) begin
                    r_acc <= r_acc << 2;
                    if (s_rem2 >= s_trial) begin
                        r_srem <= s_rem2 - s_trial;
                        r_root <= {r_root[R-2:0], 1'b1};
                    end else begin
                        r_srem <= s_rem2;
                        r_root <= {r_root[R-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[sv/idsc_back.sv]
// Back part: accumulators, percentage divide and result build.
`default_nettype none
module idsc_back #(
    parameter int P = 22,
    parameter int F = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    input  wire logic [idsc_pkg::TOL_W-1:0]   i_cfg_data,
    input  wire logic                         i_q_empty,
    input  wire logic [F+1:0]                 i_q_data,
    output logic                              o_q_pop,
    output logic                              o_r_push,
    output idsc_pkg::t_result                 o_r_data,
    input  wire logic                         i_r_full
);
    localparam int CNTW = P + 1;
    localparam int SW   = P + F + 1;
    localparam int NW   = SW + idsc_pkg::QUO_BITS;
    localparam int QB   = idsc_pkg::QUO_BITS;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_MUL  = 3'd1;
    localparam logic [2:0] B_DIV  = 3'd2;
    localparam logic [2:0] B_FIN  = 3'd3;
    localparam logic [2:0] B_OUT  = 3'd4;

    logic [2:0]                 r_state;
    logic [idsc_pkg::TOL_W-1:0] r_tol;
    logic [CNTW-1:0]            r_pix, r_counted;
    logic [SW-1:0]              r_sum;
    logic [F-1:0]               r_largest;
    logic [NW-1:0]              r_num, r_dv;
    logic [QB-1:0]              r_q;
    logic [3:0]                 r_i;
    idsc_pkg::t_result          r_res;

    logic [F:0]     q_dist;
    logic [F+8:0]   q_m;
    logic           q_counts;
    logic [F-1:0]   q_shown;
    logic [NW-1:0]  div_sh;
    logic           round_up, fail;
    logic [QB-1:0]  hund;
    idsc_pkg::t_result lvl_res;

    always_comb begin
        q_dist   = i_q_data[F:0];
        q_m      = ((F+9)'(q_dist) << 8) - (F+9)'(q_dist);
        q_counts = (q_m >= ((F+9)'(1) << F));
        q_shown  = q_dist[F] ? '1 : q_dist[F-1:0];
        div_sh   = r_dv << r_i;
        round_up = ((r_num << 1) >= r_dv);
        fail     = (r_q > QB'(r_tol)) || ((r_q == QB'(r_tol)) && (r_num != '0));
        hund     = r_q + QB'(round_up);
        if (hund == '0) hund = QB'(1);
        lvl_res            = '0;
        lvl_res.diff_level = q_m[F+7:F];
    end

    assign o_q_pop  = (r_state == B_IDLE) && !i_q_empty;
    assign o_r_push = (r_state == B_OUT);
    assign o_r_data = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_tol     <= '0;
            r_pix     <= '0;
            r_counted <= '0;
            r_sum     <= '0;
            r_largest <= '0;
        end else begin
            if (i_cfg_valid) r_tol <= i_cfg_data;
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        // pixels past the count limit give a level only
                        if (!r_pix[P]) begin
                            r_pix <= r_pix + 1'b1;
                            if (q_counts) begin
                                r_counted <= r_counted + 1'b1;
                                r_sum     <= r_sum + SW'(q_dist);
                                if (q_shown > r_largest) r_largest <= q_shown;
                            end
                        end
                        r_state <= i_q_data[F+1] ? B_MUL : B_OUT;
                    end
                end
                B_MUL: r_state <= B_DIV;
                B_DIV: if (r_i == 4'd0) r_state <= B_FIN;
                B_FIN: begin
                    r_pix     <= '0;
                    r_counted <= '0;
                    r_sum     <= '0;
                    r_largest <= '0;
                    r_state   <= B_OUT;
                end
                B_OUT: if (!i_r_full) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_res <= lvl_res;
            end
            B_MUL: begin
                r_num <= NW'(r_sum) * NW'(idsc_pkg::PCT_SCALE);
                r_dv  <= NW'(r_pix) << F;
                r_q   <= '0;
                r_i   <= 4'(QB-1);
            end
            B_DIV: begin
                if (r_num >= div_sh) begin
                    r_num    <= r_num - div_sh;
                    r_q[r_i] <= 1'b1;
                end
                if (r_i != 4'd0) r_i <= r_i - 1'b1;
            end
            B_FIN: begin
                r_res.summary_valid         <= 1'b1;
                r_res.failed                <= fail;
                r_res.difference_hundredths <= fail ? idsc_pkg::TOL_W'(hund) : '0;
                r_res.different_count       <= idsc_pkg::COUNT_W'(r_counted);
                r_res.max_distance          <= idsc_pkg::MAXD_W'(r_largest);
            end
            default: ;
        endcase
    end

    ap_pass_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_OUT && !r_res.failed) |-> (r_res.difference_hundredths == '0))
        else $error("nonzero difference on a passing result");
    ap_fail_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_OUT && r_res.failed) |-> (r_res.difference_hundredths != '0))
        else $error("failing result with zero difference");
    ap_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FIN) |=> (r_pix == '0 && r_sum == '0 && r_counted == '0))
        else $error("accumulators not cleared after summary");

endmodule
`default_nettype wire

[sv/image_difference_scorer.sv]
// Top level of the image difference scorer.
//
//  channel   direction  handshake             payload
//  pixels    in         push / full           i_pixel   (idsc_pkg::t_pixel_in)
//  results   out        pop / empty           o_result  (idsc_pkg::t_result)
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_data (tolerance, hundredths)
//
// Each pixel request passes through the front's bit-serial channel divides
// and square root before the next one is accepted (full stays high while
// the front is busy). A last pixel also runs the percentage divide in the back;
// the front keeps working on the next pixel meanwhile.
// Synchronous active-low reset clears control state, tolerance and totals.
// A full result queue stalls the back; a full distance queue stalls the front.
`default_nettype none
module image_difference_scorer #(
    parameter int PIXEL_COUNT_BITS   = 22,
    parameter int DISTANCE_FRAC_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire idsc_pkg::t_pixel_in        i_pixel,
    output logic                            empty,
    input  wire logic                       pop,
    output idsc_pkg::t_result               o_result,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [idsc_pkg::TOL_W-1:0] i_cfg_data
);
    localparam int F  = DISTANCE_FRAC_BITS;
    localparam int RW = $bits(idsc_pkg::t_result);

    // front to back: {last, distance Q1.F}
    logic          fq_push, fq_full, fq_pop, fq_empty;
    logic [F+1:0]  fq_wdata, fq_rdata;
    logic          rq_push, rq_full;
    idsc_pkg::t_result rq_wdata;
    logic [RW-1:0] rq_rdata;
    logic          front_busy;

    assign full        = front_busy;
    assign o_cfg_ready = 1'b1;
    assign o_result    = idsc_pkg::t_result'(rq_rdata);

    idsc_front #(.F(F)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pixel  (i_pixel),
        .o_busy   (front_busy),
        .o_q_push (fq_push),
        .o_q_data (fq_wdata),
        .i_q_full (fq_full)
    );

    idsc_fifo #(.W(F+2), .DEPTH(2)) u_dist_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_wdata (fq_wdata),
        .o_full  (fq_full),
        .i_pop   (fq_pop),
        .o_empty (fq_empty),
        .o_rdata (fq_rdata)
    );

    idsc_back #(.P(PIXEL_COUNT_BITS), .F(F)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (fq_empty),
        .i_q_data    (fq_rdata),
        .o_q_pop     (fq_pop),
        .o_r_push    (rq_push),
        .o_r_data    (rq_wdata),
        .i_r_full    (rq_full)
    );

    idsc_fifo #(.W(RW), .DEPTH(2)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_wdata (rq_wdata),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_rdata (rq_rdata)
    );

endmodule
`default_nettype wire
